FILE: hdl/tlmrh_pkg.sv
`default_nettype none
package tlmrh_pkg;

	localparam int LANE_COUNT = 3;
	localparam int WORD_W     = 64;
	localparam int HALF_W     = 32;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [HALF_W-1:0] half_t;

	localparam word_t SEED0 = 64'hFA153BE9AB2842EA;
	localparam word_t SEED1 = 64'hBABABABA01032587;
	localparam word_t SEED2 = 64'hC0DE15500DAFFAE7;

	localparam half_t BYTE_MULT = 32'h10E93214;
	localparam half_t MIX_MULT  = 32'h5BD1E995;

	localparam int FIN_SHIFT_A = 31;
	localparam int FIN_SHIFT_B = 33;

	// Datapath operations issued by the controller.
	typedef logic [3:0] dp_op_t;
	localparam dp_op_t OP_NONE     = 4'd0;
	localparam dp_op_t OP_ABS_XOR  = 4'd1;  // lanes ^ (swapped byte * BYTE_MULT)
	localparam dp_op_t OP_ABS_MUL  = 4'd2;  // partial products of x * MIX_MULT
	localparam dp_op_t OP_ABS_ROT  = 4'd3;  // sum, xor shift, rotate into lanes
	localparam dp_op_t OP_FIN_MULB = 4'd4;  // partial products of next lane * BYTE_MULT
	localparam dp_op_t OP_FIN_XOR  = 4'd5;  // x = h ^ product ^ (h >> 31)
	localparam dp_op_t OP_FIN_MULM = 4'd6;  // partial products of x * MIX_MULT
	localparam dp_op_t OP_FIN_LANE = 4'd7;  // finished lane enters slot 2, lanes shift down
	localparam dp_op_t OP_EMIT     = 4'd8;  // load digest register, reseed lanes

	function automatic word_t rotl64(input word_t x, input int unsigned r);
		return (x << r) | (x >> (WORD_W - r));
	endfunction

	function automatic word_t lane_seed(input int unsigned i);
		word_t s;
		case (i)
			0: s = SEED0;
			1: s = SEED1;
			default: s = SEED2;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/tlmrh_msg_if.sv
`default_nettype none
interface tlmrh_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

FILE: hdl/tlmrh_digest_if.sv
`default_nettype none
interface tlmrh_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word0;
	logic [63:0] digest_word1;
	logic [63:0] digest_word2;

	modport source (output valid, output digest_word0, output digest_word1,
		output digest_word2, input ready);
	modport sink (input valid, input digest_word0, input digest_word1,
		input digest_word2, output ready);
endinterface
`default_nettype wire

FILE: hdl/tlmrh_ctrl.sv
`default_nettype none
module tlmrh_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            msg_valid,
	input  wire logic            msg_last,
	output logic                 msg_ready,
	input  wire logic            digest_ready,
	output logic                 digest_valid,
	output tlmrh_pkg::dp_op_t    op
);
	import tlmrh_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_AMUL = 3'd1;
	localparam logic [2:0] S_AROT = 3'd2;
	localparam logic [2:0] S_FMB  = 3'd3;
	localparam logic [2:0] S_FX   = 3'd4;
	localparam logic [2:0] S_FMM  = 3'd5;
	localparam logic [2:0] S_FL   = 3'd6;
	localparam logic [2:0] S_EMIT = 3'd7;

	logic [2:0] state_q, state_d;
	logic       last_q;
	logic [1:0] fin_cnt_q;
	logic       out_valid_q;
	logic       slot_free;
	logic       emit;

	assign msg_ready    = (state_q == S_IDLE);
	assign digest_valid = out_valid_q;
	assign slot_free    = !out_valid_q || digest_ready;
	assign emit         = (state_q == S_EMIT) && slot_free;

	always_comb begin
		state_d = state_q;
		op      = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (msg_valid) begin
					op      = OP_ABS_XOR;
					state_d = S_AMUL;
				end
			end
			S_AMUL: begin
				op      = OP_ABS_MUL;
				state_d = S_AROT;
			end
			S_AROT: begin
				op      = OP_ABS_ROT;
				state_d = last_q ? S_FMB : S_IDLE;
			end
			S_FMB: begin
				op      = OP_FIN_MULB;
				state_d = S_FX;
			end
			S_FX: begin
				op      = OP_FIN_XOR;
				state_d = S_FMM;
			end
			S_FMM: begin
				op      = OP_FIN_MULM;
				state_d = S_FL;
			end
			S_FL: begin
				op      = OP_FIN_LANE;
				state_d = (fin_cnt_q == 2'(LANE_COUNT - 1)) ? S_EMIT : S_FMB;
			end
			S_EMIT: begin
				if (slot_free) begin
					op      = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= 1'b0;
			fin_cnt_q   <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (msg_valid && msg_ready) begin
				last_q <= msg_last;
			end
			if (state_q == S_AROT) begin
				fin_cnt_q <= 2'd0;
			end else if (state_q == S_FL) begin
				fin_cnt_q <= fin_cnt_q + 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (digest_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: hdl/tlmrh_dp.sv
`default_nettype none
module tlmrh_dp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tlmrh_pkg::dp_op_t  op,
	input  wire logic [7:0]         data_byte,
	output tlmrh_pkg::word_t        digest_word0,
	output tlmrh_pkg::word_t        digest_word1,
	output tlmrh_pkg::word_t        digest_word2
);
	import tlmrh_pkg::*;

	// Finalization always works on slot 0 with slot 1 as its neighbor; each
	// finished lane is shifted in at slot 2, so after three lanes the
	// original order is back.
	word_t lane_q [LANE_COUNT];
	word_t x_q    [LANE_COUNT];
	word_t plo_q  [LANE_COUNT];
	half_t phi_q  [LANE_COUNT];
	word_t dig_q  [LANE_COUNT];

	word_t      mul_a [LANE_COUNT];
	word_t      prod  [LANE_COUNT];
	half_t      mul_k;
	logic [7:0] swapped;
	logic [39:0] term;

	assign swapped = {data_byte[3:0], data_byte[7:4]};
	assign term    = 40'(swapped) * 40'(BYTE_MULT);
	assign mul_k   = (op == OP_FIN_MULB) ? BYTE_MULT : MIX_MULT;

	always_comb begin
		for (int i = 0; i < LANE_COUNT; i++) begin
			mul_a[i] = (op == OP_FIN_MULB) ? lane_q[(i + 1) % LANE_COUNT] : x_q[i];
			prod[i]  = plo_q[i] + {phi_q[i], {HALF_W{1'b0}}};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LANE_COUNT; i++) begin
			if (op == OP_ABS_XOR) begin
				x_q[i] <= lane_q[i] ^ 64'(term);
			end else if (op == OP_FIN_XOR) begin
				x_q[i] <= lane_q[i] ^ prod[i] ^ (lane_q[i] >> FIN_SHIFT_A);
			end
			if (op == OP_ABS_MUL || op == OP_FIN_MULB || op == OP_FIN_MULM) begin
				plo_q[i] <= 64'(mul_a[i][HALF_W-1:0]) * 64'(mul_k);
				phi_q[i] <= mul_a[i][WORD_W-1:HALF_W] * mul_k;
			end
		end
		if (op == OP_EMIT) begin
			for (int i = 0; i < LANE_COUNT; i++) begin
				dig_q[i] <= lane_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANE_COUNT; i++) begin
				lane_q[i] <= lane_seed(i);
			end
		end else begin
			case (op)
				OP_ABS_ROT: begin
					for (int i = 0; i < LANE_COUNT; i++) begin
						lane_q[i] <= rotl64(prod[i] ^ (x_q[i] >> (i + 1)), 5 + i);
					end
				end
				OP_FIN_LANE: begin
					lane_q[0] <= lane_q[1];
					lane_q[1] <= lane_q[2];
					lane_q[2] <= prod[0] ^ (x_q[0] >> FIN_SHIFT_B);
				end
				OP_EMIT: begin
					for (int i = 0; i < LANE_COUNT; i++) begin
						lane_q[i] <= lane_seed(i);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign digest_word0 = dig_q[0];
	assign digest_word1 = dig_q[1];
	assign digest_word2 = dig_q[2];

endmodule
`default_nettype wire

FILE: hdl/three_lane_multiply_rotate_hash.sv
`default_nettype none
// Channel   Role    Payload                                     Transfer
// msg       sink    data_byte[7:0], last_byte                   valid && ready
// digest    source  digest_word0/1/2[63:0] (lane 0 is the MSW)  valid && ready
//
// An ordinary byte runs lane XOR, split 32-bit partial products
// against the mixing constant, then sum, shift-XOR and rotate in all three lanes.
// A last byte adds finalization lane by lane (byte multiply, XOR, mix multiply,
// shift-in; both multiplies share one multiplier pair), then the digest load.
// Reset clears the controller and returns the lanes to their seeds.
// A digest waits in its own register; the next message's bytes are taken
// meanwhile and only loading the following digest stalls on it.
module three_lane_multiply_rotate_hash (
	input wire logic    clk,
	input wire logic    arst_n,
	tlmrh_msg_if.sink   msg,
	tlmrh_digest_if.source digest
);
	import tlmrh_pkg::*;

	dp_op_t op;

	// The controller sequences one byte at a time and owns every handshake.
	tlmrh_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg.valid),
		.msg_last     (msg.last_byte),
		.msg_ready    (msg.ready),
		.digest_ready (digest.ready),
		.digest_valid (digest.valid),
		.op           (op)
	);

	// The datapath holds the lanes, the multipliers and the digest register.
	tlmrh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.data_byte    (msg.data_byte),
		.digest_word0 (digest.digest_word0),
		.digest_word1 (digest.digest_word1),
		.digest_word2 (digest.digest_word2)
	);

endmodule
`default_nettype wire
